// ===== rtl/m2h_pkg.sv =====
// shared types and constants for the murmur2 32-bit hash core
// no dependencies; used by every module under rtl except m2h_queue

package m2h_pkg;

  // mixing multiplier and shift amounts
  localparam logic [31:0] MIX_MULT    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // default depth of the queues between the parts
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // what an item does to the running hash
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FULL = 2'd1,
    KIND_TAIL = 2'd2
  } kind_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        first;
    logic [31:0] length;
    logic [31:0] data;
    kind_t       kind;
    logic        last;
  } item_t;

endpackage

// ===== rtl/m2h_queue.sv =====
// small first-in first-out queue with a register-array store
// no package dependency; used between front and back and on the result side

module m2h_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/m2h_front.sv =====
// front part: takes input beats, classifies them and mixes full words
// depends on m2h_pkg; feeds the queue in front of m2h_back

module m2h_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  logic               first_item,
  input  logic [31:0]        key_length,
  input  logic [31:0]        key_word,
  input  logic [2:0]         byte_count,
  input  logic               last_item,
  output logic               out_vld,
  input  logic               out_full,
  output m2h_pkg::item_t     out_item
);

  logic           s1_v_r;
  m2h_pkg::item_t s1_item_r, s1_item_nxt;
  logic [31:0]    s1_prod_r;
  logic           s2_v_r;
  m2h_pkg::item_t s2_item_r, s2_item_nxt;
  logic           s1_en, s2_en;
  logic [31:0]    mix_x;
  logic [31:0]    mix_prod;

  // stall chain: a stage moves when it is empty or its successor moves
  assign s2_en  = !s2_v_r || !out_full;
  assign s1_en  = !s1_v_r || s2_en;
  assign in_rdy = s1_en;

  // classify by byte count and mask off unused bytes of a tail
  always_comb begin
    s1_item_nxt.first  = first_item;
    s1_item_nxt.length = key_length;
    s1_item_nxt.last   = last_item;
    unique case (byte_count)
      3'd0: begin
        s1_item_nxt.kind = m2h_pkg::KIND_NONE;
        s1_item_nxt.data = key_word;
      end
      3'd1: begin
        s1_item_nxt.kind = m2h_pkg::KIND_TAIL;
        s1_item_nxt.data = key_word & 32'h0000_00ff;
      end
      3'd2: begin
        s1_item_nxt.kind = m2h_pkg::KIND_TAIL;
        s1_item_nxt.data = key_word & 32'h0000_ffff;
      end
      3'd3: begin
        s1_item_nxt.kind = m2h_pkg::KIND_TAIL;
        s1_item_nxt.data = key_word & 32'h00ff_ffff;
      end
      default: begin
        s1_item_nxt.kind = m2h_pkg::KIND_FULL;
        s1_item_nxt.data = key_word;
      end
    endcase
  end

  // second half of the word mix
  assign mix_x    = s1_prod_r ^ (s1_prod_r >> m2h_pkg::MIX_SHIFT);
  assign mix_prod = mix_x * m2h_pkg::MIX_MULT;

  always_comb begin
    s2_item_nxt = s1_item_r;
    if (s1_item_r.kind == m2h_pkg::KIND_FULL) begin
      s2_item_nxt.data = mix_prod;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= in_vld;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_item_r <= s1_item_nxt;
      s1_prod_r <= key_word * m2h_pkg::MIX_MULT;
    end
    if (s2_en) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign out_vld  = s2_v_r;
  assign out_item = s2_item_r;

endmodule

// ===== rtl/m2h_back.sv =====
// back part: folds classified items into the running hash and finalises
// depends on m2h_pkg; reads the middle queue, writes the result queue

module m2h_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    seed,
  input  logic           q_empty,
  input  m2h_pkg::item_t q_item,
  output logic           q_pop,
  output logic           res_push,
  input  logic           res_full,
  output logic [31:0]    res_data
);

  logic [31:0] running_hash_r;
  logic [31:0] h_start;
  logic [31:0] mul_op;
  logic [31:0] mul_prod;
  logic [31:0] h_nxt;
  logic        hfin_v_r;
  logic [31:0] hfin_r;
  logic        mul_v_r;
  logic [31:0] mul_r;
  logic [31:0] fin_x;
  logic        fin_en, mul_en;

  assign mul_en = !mul_v_r || !res_full;
  assign fin_en = !hfin_v_r || mul_en;
  assign q_pop  = !q_empty && fin_en;

  // hash update: one shared multiplier per beat
  assign h_start  = q_item.first ? (seed ^ q_item.length) : running_hash_r;
  assign mul_op   = (q_item.kind == m2h_pkg::KIND_TAIL) ? (h_start ^ q_item.data) : h_start;
  assign mul_prod = mul_op * m2h_pkg::MIX_MULT;

  always_comb begin
    unique case (q_item.kind)
      m2h_pkg::KIND_FULL: h_nxt = mul_prod ^ q_item.data;
      m2h_pkg::KIND_TAIL: h_nxt = mul_prod;
      default:            h_nxt = h_start;
    endcase
  end

  // finalisation first xor-shift
  assign fin_x = hfin_r ^ (hfin_r >> m2h_pkg::FIN_SHIFT_A);

  // control state and running hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_hash_r <= '0;
      hfin_v_r       <= 1'b0;
      mul_v_r        <= 1'b0;
    end else begin
      if (q_pop) begin
        running_hash_r <= h_nxt;
      end
      if (fin_en) begin
        hfin_v_r <= q_pop && q_item.last;
      end
      if (mul_en) begin
        mul_v_r <= hfin_v_r;
      end
    end
  end

  // finalisation payload stages
  always_ff @(posedge clk) begin
    if (fin_en) begin
      hfin_r <= h_nxt;
    end
    if (mul_en) begin
      mul_r <= fin_x * m2h_pkg::MIX_MULT;
    end
  end

  assign res_push = mul_v_r && !res_full;
  assign res_data = mul_r ^ (mul_r >> m2h_pkg::FIN_SHIFT_B);

endmodule

// ===== rtl/murmur2_hash_32_core.sv =====
// A result passes through front stages s1 and s2, the middle queue, the back's hfin_r and mul_r
// registers, and the result queue.
// Throughput: one input beat per cycle when nothing stalls, held by the single hash-update
// multiplier in m2h_back that must finish each beat before the next beat reads the
// running hash. Reset (synchronous, rst_n low): queues and pipeline valids cleared,
// running hash 0, hash seed 0.

module murmur2_hash_32_core #(
  parameter int unsigned QUEUE_DEPTH = m2h_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic        in_first_item,
  input  logic [31:0] in_key_length,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_item,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_hash_value
);

  localparam int unsigned ITEM_W = $bits(m2h_pkg::item_t);

  logic [31:0]    hash_seed_r;
  logic           in_rdy;
  logic           fr_vld;
  m2h_pkg::item_t fr_item;
  logic           mq_full, mq_empty, mq_pop;
  logic [ITEM_W-1:0] mq_rdata;
  m2h_pkg::item_t mq_item;
  logic           res_push, res_full;
  logic [31:0]    res_data;

  // seed register; the only register, so every word offset maps to it
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? hash_seed_r : hash_seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      hash_seed_r <= pwdata;
    end
  end

  assign full = !in_rdy;

  m2h_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (push),
    .in_rdy     (in_rdy),
    .first_item (in_first_item),
    .key_length (in_key_length),
    .key_word   (in_key_word),
    .byte_count (in_byte_count),
    .last_item  (in_last_item),
    .out_vld    (fr_vld),
    .out_full   (mq_full),
    .out_item   (fr_item)
  );

  // queue between front and back
  m2h_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_vld),
    .wdata (fr_item),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  assign mq_item = m2h_pkg::item_t'(mq_rdata);

  m2h_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (hash_seed_r),
    .q_empty  (mq_empty),
    .q_item   (mq_item),
    .q_pop    (mq_pop),
    .res_push (res_push),
    .res_full (res_full),
    .res_data (res_data)
  );

  // result queue
  m2h_queue #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_hash_value),
    .empty (empty)
  );

endmodule
